// File: hw/rtl/pat_pkg.sv
`default_nettype none

package pat_pkg;

   // fixed-point format of positions and scale factors
   localparam int FRAC_BITS = 16;
   // angle resolution: one full turn is 2**ANGLE_BITS
   localparam int ANGLE_BITS = 16;

   localparam int CORDIC_STEPS = 24;
   localparam int CORDIC_IDX_W = $clog2(CORDIC_STEPS);
   localparam logic [CORDIC_IDX_W-1:0] CORDIC_LAST = CORDIC_IDX_W'(CORDIC_STEPS - 1);
   localparam int CORDIC_XW = 34;
   localparam int CORDIC_ZW = 33;
   // 1/K scaled by 2**30
   localparam logic signed [CORDIC_XW-1:0] CORDIC_GAIN = CORDIC_XW'(652032874);
   localparam logic signed [31:0] ONE_Q30 = 32'sd1073741824;

   localparam int MUL_AW = 33;
   localparam int MUL_BW = 32;
   localparam int PROD_W = MUL_AW + MUL_BW;
   localparam int ACC_W = PROD_W + 1;
   localparam int SAT_W = ACC_W + 1;

   localparam int ROT_SHIFT = 30;

   localparam logic [7:0] HIT_MARGIN_RESET = 8'd5;

   // multiply-accumulate schedule
   localparam int STEP_W = 3;
   localparam logic [STEP_W-1:0] ROT_CAPX_STEP = 3'd3;
   localparam logic [STEP_W-1:0] ROT_LAST_STEP = 3'd5;
   localparam logic [STEP_W-1:0] SCL_CAPX_STEP = 3'd2;
   localparam logic [STEP_W-1:0] SCL_LAST_STEP = 3'd3;

   typedef enum logic [2:0] {
      ACT_PLACE     = 3'd0,
      ACT_TRANSLATE = 3'd1,
      ACT_ROTATE    = 3'd2,
      ACT_SCALE     = 3'd3,
      ACT_HIT       = 3'd4
   } action_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CORDIC,
      ST_MAC,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic issue;   // operands valid this cycle
      logic clear;   // restart accumulation from the rounding bias
      logic sub;     // subtract the product instead of adding
      logic rot;     // rotation rounding (2**-30) instead of scale rounding
   } mac_ctrl_type;

   // atan(2**-i) in units of 2**-32 turn
   function automatic logic [29:0] atan_turn(input logic [CORDIC_IDX_W-1:0] idx);
      logic [29:0] val;
      case (idx)
         5'd0:    val = 30'd536870912;
         5'd1:    val = 30'd316933406;
         5'd2:    val = 30'd167458907;
         5'd3:    val = 30'd85004756;
         5'd4:    val = 30'd42667331;
         5'd5:    val = 30'd21354465;
         5'd6:    val = 30'd10679838;
         5'd7:    val = 30'd5340245;
         5'd8:    val = 30'd2670163;
         5'd9:    val = 30'd1335087;
         5'd10:   val = 30'd667544;
         5'd11:   val = 30'd333772;
         5'd12:   val = 30'd166886;
         5'd13:   val = 30'd83443;
         5'd14:   val = 30'd41722;
         5'd15:   val = 30'd20861;
         5'd16:   val = 30'd10430;
         5'd17:   val = 30'd5215;
         5'd18:   val = 30'd2608;
         5'd19:   val = 30'd1304;
         5'd20:   val = 30'd652;
         5'd21:   val = 30'd326;
         5'd22:   val = 30'd163;
         5'd23:   val = 30'd81;
         default: val = '0;
      endcase
      return val;
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [SAT_W-1:0] v);
      logic [SAT_W-32:0] top;
      top = v[SAT_W-1:31];
      if (top == '0 || top == '1)
         return v[31:0];
      else if (v[SAT_W-1])
         return 32'sh8000_0000;
      else
         return 32'sh7fff_ffff;
   endfunction

endpackage

`default_nettype wire

// File: hw/rtl/pat_cordic.sv
`default_nettype none

// Iterative rotation-mode CORDIC: one micro-rotation per cycle over the first
// quadrant, then a quadrant fold and clamp to [-1, 1] in Q2.30.
module pat_cordic (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   input  wire logic [31:0]         phase,
   output logic                     done,
   output logic signed [31:0]       cos_q30,
   output logic signed [31:0]       sin_q30
);

   localparam int XW = pat_pkg::CORDIC_XW;
   localparam int ZW = pat_pkg::CORDIC_ZW;

   logic                              busy_ff, busy_in;
   logic                              fold_ff, fold_in;
   logic                              done_ff, done_in;
   logic [pat_pkg::CORDIC_IDX_W-1:0]  iter_ff, iter_in;
   logic signed [XW-1:0]              x_ff, x_in;
   logic signed [XW-1:0]              y_ff, y_in;
   logic signed [ZW-1:0]              z_ff, z_in;
   logic [1:0]                        quad_ff, quad_in;
   logic signed [31:0]                cos_ff, cos_in;
   logic signed [31:0]                sin_ff, sin_in;

   logic signed [XW-1:0]              xs, ys;
   logic signed [ZW-1:0]              at;
   logic signed [XW:0]                xe, ye, xn, yn;

   function automatic logic signed [31:0] clamp_unit(input logic signed [XW:0] v);
      if (v > (XW+1)'(pat_pkg::ONE_Q30))
         return pat_pkg::ONE_Q30;
      else if (v < -((XW+1)'(pat_pkg::ONE_Q30)))
         return -pat_pkg::ONE_Q30;
      else
         return v[31:0];
   endfunction

   always_comb begin
      busy_in = busy_ff;
      fold_in = 1'b0;
      done_in = 1'b0;
      iter_in = iter_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      quad_in = quad_ff;
      cos_in  = cos_ff;
      sin_in  = sin_ff;

      xs = x_ff >>> iter_ff;
      ys = y_ff >>> iter_ff;
      at = ZW'(pat_pkg::atan_turn(iter_ff));
      xe = (XW+1)'(x_ff);
      ye = (XW+1)'(y_ff);
      xn = -xe;
      yn = -ye;

      if (start) begin
         busy_in = 1'b1;
         iter_in = '0;
         x_in    = pat_pkg::CORDIC_GAIN;
         y_in    = '0;
         z_in    = ZW'({phase[29:0]});
         quad_in = phase[31:30];
      end else if (busy_ff) begin
         if (!z_ff[ZW-1]) begin
            x_in = x_ff - ys;
            y_in = y_ff + xs;
            z_in = z_ff - at;
         end else begin
            x_in = x_ff + ys;
            y_in = y_ff - xs;
            z_in = z_ff + at;
         end
         iter_in = iter_ff + 1'b1;
         if (iter_ff == pat_pkg::CORDIC_LAST) begin
            busy_in = 1'b0;
            fold_in = 1'b1;
         end
      end

      if (fold_ff) begin
         done_in = 1'b1;
         case (quad_ff)
            2'd0: begin
               cos_in = clamp_unit(xe);
               sin_in = clamp_unit(ye);
            end
            2'd1: begin
               cos_in = clamp_unit(yn);
               sin_in = clamp_unit(xe);
            end
            2'd2: begin
               cos_in = clamp_unit(xn);
               sin_in = clamp_unit(yn);
            end
            default: begin
               cos_in = clamp_unit(ye);
               sin_in = clamp_unit(xn);
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fold_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         fold_ff <= fold_in;
         done_ff <= done_in;
      end
      iter_ff <= iter_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      quad_ff <= quad_in;
      cos_ff  <= cos_in;
      sin_ff  <= sin_in;
   end

   assign done    = done_ff;
   assign cos_q30 = cos_ff;
   assign sin_q30 = sin_ff;

endmodule

`default_nettype wire

// File: hw/rtl/pat_mac.sv
`default_nettype none

// Shared multiplier with registered product, followed in the next cycle by the
// accumulator. Control travels with the product.
module pat_mac (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire pat_pkg::mac_ctrl_type              ctrl,
   input  wire logic signed [pat_pkg::MUL_AW-1:0]  op_a,
   input  wire logic signed [pat_pkg::MUL_BW-1:0]  op_b,
   output logic signed [pat_pkg::ACC_W-1:0]        acc
);

   localparam int AW = pat_pkg::ACC_W;
   localparam logic signed [AW-1:0] BIAS_ROT = AW'(1) <<< (pat_pkg::ROT_SHIFT - 1);
   localparam logic signed [AW-1:0] BIAS_SCL = AW'(1) <<< (pat_pkg::FRAC_BITS - 1);

   pat_pkg::mac_ctrl_type                  ctrl_ff;
   logic signed [pat_pkg::PROD_W-1:0]      prod_ff, prod_in;
   logic signed [AW-1:0]                   acc_ff, acc_in;
   logic signed [AW-1:0]                   base, term;

   always_comb begin
      prod_in = op_a * op_b;
      base    = ctrl_ff.clear ? (ctrl_ff.rot ? BIAS_ROT : BIAS_SCL) : acc_ff;
      term    = ctrl_ff.sub ? -(AW'(prod_ff)) : AW'(prod_ff);
      acc_in  = ctrl_ff.issue ? base + term : acc_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff <= '0;
      end else begin
         ctrl_ff <= ctrl;
      end
      if (ctrl.issue) begin
         prod_ff <= prod_in;
      end
      acc_ff <= acc_in;
   end

   assign acc = acc_ff;

endmodule

`default_nettype wire

// File: hw/rtl/point_affine_transform_unit.sv
`default_nettype none

// Holds one 2D point in signed Q16.16 and applies one operation per request
// transaction (tuser): place, translate, rotate about a pivot, scale about a
// pivot, or hit test against a query point; every request returns exactly one
// response with the point after the operation and the hit flag, positions
// saturating to 32 bits. One request is in flight at a time and req_tready is
// low while it runs. Rotate runs 24 CORDIC micro-rotations plus a quadrant
// fold, then four products through the one shared 33x32 multiplier-accumulator;
// scale runs two products through that multiplier; place, translate, hit test
// and unused codes go straight to the response. Each may then wait for the
// previous response to be taken. hit_margin is written on the csr channel,
// which is always ready; it resets to 5.
module point_affine_transform_unit (
   input  wire logic          clock,
   input  wire logic          reset,

   input  wire logic          csr_valid,
   output logic               csr_ready,
   input  wire logic [7:0]    csr_data,        // hit_margin

   input  wire logic          req_tvalid,
   output logic               req_tready,
   // [31:0] coord_x, [63:32] coord_y, [95:64] factor_x, [127:96] factor_y,
   // [143:128] angle
   input  wire logic [143:0]  req_tdata,
   input  wire logic [2:0]    req_tuser,       // [2:0] action

   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   output logic [71:0]        rsp_tdata        // [31:0] pos_x, [63:32] pos_y, [64] selected
);

   localparam int AW = pat_pkg::MUL_AW;
   localparam int BW = pat_pkg::MUL_BW;
   localparam logic [31:0] ANGLE_MASK = 32'((64'd1 << pat_pkg::ANGLE_BITS) - 64'd1);

   pat_pkg::state_type           state_ff, state_in;
   pat_pkg::action_type          act_ff;
   logic [pat_pkg::STEP_W-1:0]   step_ff, step_in;
   logic signed [31:0]           cx_ff, cy_ff, fx_ff, fy_ff;
   logic signed [AW-1:0]         dx_ff, dy_ff;
   logic signed [31:0]           rx_ff, ry_ff;
   logic signed [31:0]           point_x_ff, point_y_ff;
   logic [7:0]                   margin_ff;
   logic                         rsp_valid_ff;
   logic signed [31:0]           rsp_x_ff, rsp_y_ff;
   logic                         rsp_sel_ff;

   logic                         req_fire, rsp_fire;
   logic signed [31:0]           coord_x, coord_y;
   logic [31:0]                  phase;
   logic                         cordic_start, cordic_done;
   logic signed [31:0]           cos_q30, sin_q30;

   pat_pkg::mac_ctrl_type        mac_ctrl;
   logic signed [AW-1:0]         op_a;
   logic signed [BW-1:0]         op_b;
   logic signed [pat_pkg::ACC_W-1:0] acc;

   logic                         is_rot, cap_x, cap_y, load_rsp;
   logic signed [pat_pkg::ACC_W-1:0] acc_sh;
   logic signed [31:0]           cap_pivot;
   logic signed [31:0]           cap_val;
   logic signed [31:0]           new_x, new_y;
   logic                         new_sel;
   logic [AW-1:0]                ax, ay, lim;

   assign coord_x  = req_tdata[31:0];
   assign coord_y  = req_tdata[63:32];
   assign req_fire = req_tvalid && req_tready;
   assign rsp_fire = rsp_valid_ff && rsp_tready;
   assign is_rot   = (act_ff == pat_pkg::ACT_ROTATE);

   assign phase = (32'(req_tdata[143:128]) & ANGLE_MASK) << (32 - pat_pkg::ANGLE_BITS);
   assign cordic_start = req_fire && (req_tuser == pat_pkg::ACT_ROTATE);

   pat_cordic u_cordic (
      .clock   (clock),
      .reset   (reset),
      .start   (cordic_start),
      .phase   (phase),
      .done    (cordic_done),
      .cos_q30 (cos_q30),
      .sin_q30 (sin_q30)
   );

   pat_mac u_mac (
      .clock (clock),
      .reset (reset),
      .ctrl  (mac_ctrl),
      .op_a  (op_a),
      .op_b  (op_b),
      .acc   (acc)
   );

   // sequencer
   always_comb begin
      state_in   = state_ff;
      step_in    = step_ff;
      mac_ctrl   = '0;
      mac_ctrl.rot = is_rot;
      op_a       = dx_ff;
      op_b       = '0;
      cap_x      = 1'b0;
      cap_y      = 1'b0;
      load_rsp   = 1'b0;
      req_tready = 1'b0;

      unique case (state_ff)
         pat_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            step_in    = '0;
            if (req_tvalid) begin
               case (req_tuser)
                  pat_pkg::ACT_ROTATE: state_in = pat_pkg::ST_CORDIC;
                  pat_pkg::ACT_SCALE:  state_in = pat_pkg::ST_MAC;
                  default:             state_in = pat_pkg::ST_FINISH;
               endcase
            end
         end
         pat_pkg::ST_CORDIC: begin
            if (cordic_done) begin
               state_in = pat_pkg::ST_MAC;
            end
         end
         pat_pkg::ST_MAC: begin
            step_in = step_ff + 1'b1;
            if (is_rot) begin
               case (step_ff)
                  3'd0: begin
                     mac_ctrl.issue = 1'b1;
                     mac_ctrl.clear = 1'b1;
                     op_a = dx_ff;
                     op_b = cos_q30;
                  end
                  3'd1: begin
                     mac_ctrl.issue = 1'b1;
                     mac_ctrl.sub   = 1'b1;
                     op_a = dy_ff;
                     op_b = sin_q30;
                  end
                  3'd2: begin
                     mac_ctrl.issue = 1'b1;
                     mac_ctrl.clear = 1'b1;
                     op_a = dx_ff;
                     op_b = sin_q30;
                  end
                  3'd3: begin
                     mac_ctrl.issue = 1'b1;
                     op_a = dy_ff;
                     op_b = cos_q30;
                  end
                  default: ;
               endcase
               cap_x = (step_ff == pat_pkg::ROT_CAPX_STEP);
               cap_y = (step_ff == pat_pkg::ROT_LAST_STEP);
            end else begin
               case (step_ff)
                  3'd0: begin
                     mac_ctrl.issue = 1'b1;
                     mac_ctrl.clear = 1'b1;
                     op_a = dx_ff;
                     op_b = fx_ff;
                  end
                  3'd1: begin
                     mac_ctrl.issue = 1'b1;
                     mac_ctrl.clear = 1'b1;
                     op_a = dy_ff;
                     op_b = fy_ff;
                  end
                  default: ;
               endcase
               cap_x = (step_ff == pat_pkg::SCL_CAPX_STEP);
               cap_y = (step_ff == pat_pkg::SCL_LAST_STEP);
            end
            if (cap_y) begin
               state_in = pat_pkg::ST_FINISH;
            end
         end
         pat_pkg::ST_FINISH: begin
            // wait for the output register to free up
            if (!rsp_valid_ff || rsp_tready) begin
               load_rsp = 1'b1;
               state_in = pat_pkg::ST_IDLE;
            end
         end
         default: state_in = pat_pkg::ST_IDLE;
      endcase
   end

   // round/shift of the accumulator, add pivot, saturate
   always_comb begin
      acc_sh    = is_rot ? (acc >>> pat_pkg::ROT_SHIFT) : (acc >>> pat_pkg::FRAC_BITS);
      cap_pivot = cap_x ? cx_ff : cy_ff;
      cap_val   = pat_pkg::sat32(pat_pkg::SAT_W'(acc_sh) + pat_pkg::SAT_W'(cap_pivot));
   end

   // final position and hit flag
   always_comb begin
      ax  = dx_ff[AW-1] ? AW'(-dx_ff) : AW'(dx_ff);
      ay  = dy_ff[AW-1] ? AW'(-dy_ff) : AW'(dy_ff);
      lim = AW'(margin_ff) << pat_pkg::FRAC_BITS;
      new_sel = 1'b0;
      case (act_ff) inside
         pat_pkg::ACT_PLACE: begin
            new_x = cx_ff;
            new_y = cy_ff;
         end
         pat_pkg::ACT_TRANSLATE: begin
            new_x = pat_pkg::sat32(pat_pkg::SAT_W'(point_x_ff) + pat_pkg::SAT_W'(cx_ff));
            new_y = pat_pkg::sat32(pat_pkg::SAT_W'(point_y_ff) + pat_pkg::SAT_W'(cy_ff));
         end
         pat_pkg::ACT_ROTATE, pat_pkg::ACT_SCALE: begin
            new_x = rx_ff;
            new_y = ry_ff;
         end
         pat_pkg::ACT_HIT: begin
            new_x   = point_x_ff;
            new_y   = point_y_ff;
            new_sel = (ax < lim) && (ay < lim);
         end
         default: begin
            new_x = point_x_ff;
            new_y = point_y_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pat_pkg::ST_IDLE;
         step_ff      <= '0;
         point_x_ff   <= '0;
         point_y_ff   <= '0;
         margin_ff    <= pat_pkg::HIT_MARGIN_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         if (csr_valid) begin
            margin_ff <= csr_data;
         end
         if (load_rsp) begin
            point_x_ff   <= new_x;
            point_y_ff   <= new_y;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_fire) begin
            rsp_valid_ff <= 1'b0;
         end
      end

      if (req_fire) begin
         act_ff <= pat_pkg::action_type'(req_tuser);
         cx_ff  <= coord_x;
         cy_ff  <= coord_y;
         fx_ff  <= req_tdata[95:64];
         fy_ff  <= req_tdata[127:96];
         dx_ff  <= AW'(point_x_ff) - AW'(coord_x);
         dy_ff  <= AW'(point_y_ff) - AW'(coord_y);
      end
      if (cap_x) begin
         rx_ff <= cap_val;
      end
      if (cap_y) begin
         ry_ff <= cap_val;
      end
      if (load_rsp) begin
         rsp_x_ff   <= new_x;
         rsp_y_ff   <= new_y;
         rsp_sel_ff <= new_sel;
      end
   end

   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'b0, rsp_sel_ff, rsp_y_ff, rsp_x_ff};

endmodule

`default_nettype wire

// File: test/point_affine_transform_unit_tb.sv
`timescale 1ns / 100ps

module point_affine_transform_unit_tb;

   localparam logic [2:0] ACT_SPARE_5 = 3'd5;
   localparam logic [2:0] ACT_SPARE_6 = 3'd6;
   localparam logic [2:0] ACT_SPARE_7 = 3'd7;

   localparam int     ROT_ITERS  = 24;
   localparam longint UNIT_Q30   = 64'sd1073741824;
   localparam longint GAIN_Q30   = 64'sd652032874;
   localparam longint ROT_HALF   = 64'sd536870912;
   localparam longint POS_MAX    = 64'sd2147483647;
   localparam longint POS_MIN    = -64'sd2147483648;
   localparam int     TAIL_WAIT  = 40;
   localparam int     CMDS_PER_PHASE = 80;

   typedef struct {
      logic [2:0]         action;
      logic signed [31:0] cx;
      logic signed [31:0] cy;
      logic signed [31:0] fx;
      logic signed [31:0] fy;
      logic [15:0]        angle;
   } cmd_type;

   typedef struct packed {
      logic               sel;
      logic signed [31:0] py;
      logic signed [31:0] px;
   } pos_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic [7:0]   csr_data = '0;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [143:0] req_tdata = '0;
   logic [2:0]   req_tuser = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [71:0]  rsp_tdata;

   // atan(2**-i) in units of 2**-32 turn
   longint atan_turn_tbl [0:ROT_ITERS-1] = '{
      536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
      10679838, 5340245, 2670163, 1335087, 667544, 333772,
      166886, 83443, 41722, 20861, 10430, 5215,
      2608, 1304, 652, 326, 163, 81
   };

   cmd_type            cmd_q[$];
   pos_type            expected_pos_q[$];
   logic signed [31:0] track_x;
   logic signed [31:0] track_y;
   logic [7:0]         margin_model;
   int                 cmds_sent = 0;
   int                 cmds_accepted = 0;
   int                 mismatch_count = 0;
   int                 burst_left = 4;
   int                 gap_left = 0;
   int                 stall_mode = 0;
   int                 stall_left = 0;
   logic [7:0]         stall_tick = '0;

   point_affine_transform_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic logic signed [31:0] clip_to_int32(input longint v);
      if (v > POS_MAX)
         return 32'sh7fff_ffff;
      if (v < POS_MIN)
         return 32'sh8000_0000;
      return v[31:0];
   endfunction

   function automatic longint clamp_unit(input longint v);
      if (v > UNIT_Q30)
         return UNIT_Q30;
      if (v < -UNIT_Q30)
         return -UNIT_Q30;
      return v;
   endfunction

   // cosine and sine in Q2.30 for a 32-bit turn phase
   function automatic void cordic_unit_vector(input logic [31:0] phase,
                                              output longint c, output longint s);
      longint x, y, z, xs, ys;
      int     i;
      x = GAIN_Q30;
      y = 0;
      z = longint'({2'b00, phase[29:0]});
      for (i = 0; i < ROT_ITERS; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (z >= 0) begin
            x = x - ys;
            y = y + xs;
            z = z - atan_turn_tbl[i];
         end else begin
            x = x + ys;
            y = y - xs;
            z = z + atan_turn_tbl[i];
         end
      end
      case (phase[31:30])
         2'd0: begin c = x;  s = y;  end
         2'd1: begin c = -y; s = x;  end
         2'd2: begin c = -x; s = -y; end
         default: begin c = y; s = -x; end
      endcase
      c = clamp_unit(c);
      s = clamp_unit(s);
   endfunction

   // advances the tracked point by one command and returns the response it should give
   function automatic pos_type apply_point_op(input cmd_type cmd);
      longint  px, py, cx, cy, fx, fy, dx, dy, c, s, lim, ax, ay;
      pos_type res;
      px = longint'(track_x);
      py = longint'(track_y);
      cx = longint'(cmd.cx);
      cy = longint'(cmd.cy);
      fx = longint'(cmd.fx);
      fy = longint'(cmd.fy);
      dx = px - cx;
      dy = py - cy;
      res.sel = 1'b0;
      case (cmd.action)
         pat_pkg::ACT_PLACE: begin
            track_x = cmd.cx;
            track_y = cmd.cy;
         end
         pat_pkg::ACT_TRANSLATE: begin
            track_x = clip_to_int32(px + cx);
            track_y = clip_to_int32(py + cy);
         end
         pat_pkg::ACT_ROTATE: begin
            cordic_unit_vector(32'(cmd.angle) << (32 - pat_pkg::ANGLE_BITS), c, s);
            track_x = clip_to_int32(((c * dx - s * dy + ROT_HALF) >>> 30) + cx);
            track_y = clip_to_int32(((s * dx + c * dy + ROT_HALF) >>> 30) + cy);
         end
         pat_pkg::ACT_SCALE: begin
            track_x = clip_to_int32(((fx * dx + (64'sd1 <<< (pat_pkg::FRAC_BITS - 1)))
                                     >>> pat_pkg::FRAC_BITS) + cx);
            track_y = clip_to_int32(((fy * dy + (64'sd1 <<< (pat_pkg::FRAC_BITS - 1)))
                                     >>> pat_pkg::FRAC_BITS) + cy);
         end
         pat_pkg::ACT_HIT: begin
            lim = longint'(margin_model) <<< pat_pkg::FRAC_BITS;
            ax = (dx < 0) ? -dx : dx;
            ay = (dy < 0) ? -dy : dy;
            res.sel = (ax < lim && ay < lim);
         end
         default: ;
      endcase
      res.px = track_x;
      res.py = track_y;
      return res;
   endfunction

   function automatic cmd_type make_cmd(input logic [2:0] action,
                                        input logic signed [31:0] cx, cy, fx, fy,
                                        input logic [15:0] angle);
      cmd_type cmd;
      cmd.action = action;
      cmd.cx = cx;
      cmd.cy = cy;
      cmd.fx = fx;
      cmd.fy = fy;
      cmd.angle = angle;
      return cmd;
   endfunction

   function automatic logic signed [31:0] rand_coord();
      case ($urandom_range(0, 3))
         0, 1: return 32'($urandom_range(0, 131072000)) - 32'd65536000;
         2: return $urandom;
         default: begin
            case ($urandom_range(0, 3))
               0: return 32'sh7fff_ffff;
               1: return 32'sh8000_0000;
               2: return 32'sh0000_0000;
               default: return 32'shffff_ffff;
            endcase
         end
      endcase
   endfunction

   function automatic logic signed [31:0] rand_factor();
      if ($urandom_range(0, 3) == 0)
         return $urandom;
      return 32'($urandom_range(0, 524288)) - 32'd262144;
   endfunction

   task automatic queue_random_cmds(input int n, input logic [7:0] margin);
      int                 k;
      int                 span;
      logic signed [31:0] base_x, base_y;
      logic [2:0]         act;
      k = 0;
      span = (int'(margin) + 2) << pat_pkg::FRAC_BITS;
      while (k < n) begin
         if ($urandom_range(0, 99) < 15) begin
            // place then probe close to the placed point, straddling the margin
            base_x = 32'($urandom_range(0, 131072000)) - 32'd65536000;
            base_y = 32'($urandom_range(0, 131072000)) - 32'd65536000;
            cmd_q.push_back(make_cmd(pat_pkg::ACT_PLACE, base_x, base_y, $urandom, $urandom,
                                     16'($urandom)));
            cmd_q.push_back(make_cmd(pat_pkg::ACT_HIT,
                                     base_x + 32'($urandom_range(0, 2 * span)) - 32'(span),
                                     base_y + 32'($urandom_range(0, 2 * span)) - 32'(span),
                                     $urandom, $urandom, 16'($urandom)));
            k += 2;
         end else begin
            case ($urandom_range(0, 9))
               0, 1: act = pat_pkg::ACT_PLACE;
               2, 3: act = pat_pkg::ACT_TRANSLATE;
               4, 5: act = pat_pkg::ACT_ROTATE;
               6, 7: act = pat_pkg::ACT_SCALE;
               8:    act = pat_pkg::ACT_HIT;
               default: act = 3'($urandom_range(ACT_SPARE_5, ACT_SPARE_7));
            endcase
            cmd_q.push_back(make_cmd(act, rand_coord(), rand_coord(), rand_factor(),
                                     rand_factor(), 16'($urandom)));
            k++;
         end
      end
   endtask

   task automatic wait_all_done();
      while (cmd_q.size() != 0 || cmds_sent != cmds_accepted || expected_pos_q.size() != 0)
         @(negedge clock);
   endtask

   task automatic write_margin(input logic [7:0] margin);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data <= margin;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   always @(negedge clock) begin : req_driver
      cmd_type nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (cmds_sent == cmds_accepted) begin
         if (gap_left > 0) begin
            gap_left--;
            req_tvalid <= 1'b0;
         end else if (cmd_q.size() > 0) begin
            nxt = cmd_q.pop_front();
            req_tdata <= {nxt.angle, nxt.fy, nxt.fx, nxt.cy, nxt.cx};
            req_tuser <= nxt.action;
            req_tvalid <= 1'b1;
            cmds_sent++;
            if (burst_left > 1) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(1, 16);
               gap_left = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 24) : 0;
            end
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // receiver: always ready, coin flip, or one cycle in eight, switching now and then
   always @(negedge clock) begin : rsp_stall
      if (stall_left == 0) begin
         stall_mode = $urandom_range(0, 2);
         stall_left = $urandom_range(20, 200);
      end else begin
         stall_left--;
      end
      stall_tick <= stall_tick + 8'd1;
      case (stall_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= 1'($urandom_range(0, 1));
         default: rsp_tready <= (stall_tick[2:0] == 3'd0);
      endcase
   end

   always @(posedge clock) begin : bus_monitor
      pos_type got, want;
      if (reset) begin
         track_x = '0;
         track_y = '0;
         margin_model = pat_pkg::HIT_MARGIN_RESET;
      end else begin
         if (csr_valid && csr_ready)
            margin_model = csr_data;
         if (rsp_tvalid && rsp_tready) begin
            got.px = rsp_tdata[31:0];
            got.py = rsp_tdata[63:32];
            got.sel = rsp_tdata[64];
            if (expected_pos_q.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("%0t: unexpected response x=%h y=%h sel=%b",
                           $realtime, got.px, got.py, got.sel);
            end else begin
               want = expected_pos_q.pop_front();
               if (got.px !== want.px || got.py !== want.py || got.sel !== want.sel) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("%0t: response mismatch exp x=%h y=%h sel=%b got x=%h y=%h sel=%b",
                              $realtime, want.px, want.py, want.sel,
                              got.px, got.py, got.sel);
               end
            end
         end
         if (req_tvalid && req_tready) begin
            expected_pos_q.push_back(apply_point_op(make_cmd(req_tuser,
               req_tdata[31:0], req_tdata[63:32], req_tdata[95:64],
               req_tdata[127:96], req_tdata[143:128])));
            cmds_accepted++;
         end
      end
   end

   initial begin : stimulus
      logic [7:0] margin_plan [0:4];
      int         p;
      margin_plan[0] = 8'd0;
      margin_plan[1] = 8'd255;
      margin_plan[2] = 8'($urandom_range(2, 254));
      margin_plan[3] = 8'd1;
      margin_plan[4] = 8'($urandom_range(2, 40));

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // saturation on translate, both directions
      cmd_q.push_back(make_cmd(pat_pkg::ACT_PLACE, 32'sh7fff_ffff, 32'sh8000_0000, 0, 0,
                               16'h0000));
      cmd_q.push_back(make_cmd(pat_pkg::ACT_TRANSLATE, 32'sh7fff_ffff, 32'sh8000_0000, 0, 0,
                               16'h0));
      cmd_q.push_back(make_cmd(pat_pkg::ACT_PLACE, 32'sh8000_0000, 32'sh7fff_ffff, 0, 0,
                               16'h0));
      cmd_q.push_back(make_cmd(pat_pkg::ACT_TRANSLATE, -32'sd1, 32'sd1, 0, 0, 16'h0));
      // hit test against the reset margin: exactly on it, just inside, far away
      cmd_q.push_back(make_cmd(pat_pkg::ACT_PLACE, 0, 0, 0, 0, 16'h0));
      cmd_q.push_back(make_cmd(pat_pkg::ACT_HIT, 32'sd5 <<< 16, 0, 0, 0, 16'h0));
      cmd_q.push_back(make_cmd(pat_pkg::ACT_HIT, (32'sd5 <<< 16) - 1, 1 - (32'sd5 <<< 16),
                               0, 0, 16'h0));
      cmd_q.push_back(make_cmd(pat_pkg::ACT_HIT, 0, -(32'sd5 <<< 16), 0, 0, 16'h0));
      cmd_q.push_back(make_cmd(pat_pkg::ACT_HIT, 32'sh8000_0000, 32'sh8000_0000, 0, 0,
                               16'h0));
      // rotations through every quadrant and the angle extremes
      cmd_q.push_back(make_cmd(pat_pkg::ACT_PLACE, 32'sd10 <<< 16, 32'sd3 <<< 16, 0, 0,
                               16'h0));
      cmd_q.push_back(make_cmd(pat_pkg::ACT_ROTATE, 32'sd2 <<< 16, -(32'sd1 <<< 16), 0, 0,
                               16'h0000));
      cmd_q.push_back(make_cmd(pat_pkg::ACT_ROTATE, 32'sd2 <<< 16, -(32'sd1 <<< 16), 0, 0,
                               16'h4000));
      cmd_q.push_back(make_cmd(pat_pkg::ACT_ROTATE, 32'sd2 <<< 16, -(32'sd1 <<< 16), 0, 0,
                               16'h8000));
      cmd_q.push_back(make_cmd(pat_pkg::ACT_ROTATE, 32'sd2 <<< 16, -(32'sd1 <<< 16), 0, 0,
                               16'hc000));
      cmd_q.push_back(make_cmd(pat_pkg::ACT_ROTATE, 32'sd2 <<< 16, -(32'sd1 <<< 16), 0, 0,
                               16'hffff));
      cmd_q.push_back(make_cmd(pat_pkg::ACT_ROTATE, 0, 0, 0, 0, 16'h2000));
      // rotation far from the pivot saturates
      cmd_q.push_back(make_cmd(pat_pkg::ACT_PLACE, 32'sh7fff_ffff, 32'sh7fff_ffff, 0, 0,
                               16'h0));
      cmd_q.push_back(make_cmd(pat_pkg::ACT_ROTATE, 32'sh8000_0000, 32'sh8000_0000, 0, 0,
                               16'h2000));
      // scale: round half up on odd raw values, mirror, saturation, collapse to pivot
      cmd_q.push_back(make_cmd(pat_pkg::ACT_PLACE, 32'sd3, -32'sd3, 0, 0, 16'h0));
      cmd_q.push_back(make_cmd(pat_pkg::ACT_SCALE, 0, 0, 32'sh0000_8000, 32'sh0000_8000,
                               16'h0));
      cmd_q.push_back(make_cmd(pat_pkg::ACT_SCALE, 32'sd1 <<< 16, 32'sd1 <<< 16,
                               32'shffff_0000, 32'sh0001_0000, 16'h0));
      cmd_q.push_back(make_cmd(pat_pkg::ACT_PLACE, 32'sh8000_0000, 32'sh7fff_ffff, 0, 0,
                               16'h0));
      cmd_q.push_back(make_cmd(pat_pkg::ACT_SCALE, 32'sh7fff_ffff, 32'sh8000_0000,
                               32'sh8000_0000, 32'sh7fff_ffff, 16'hffff));
      cmd_q.push_back(make_cmd(pat_pkg::ACT_SCALE, 32'sd7, 32'sd9, 0, 0, 16'h0));
      // unused codes leave the point alone
      cmd_q.push_back(make_cmd(ACT_SPARE_5, -1, -1, -1, -1, 16'hffff));
      cmd_q.push_back(make_cmd(ACT_SPARE_6, 32'sh1234_5678, 0, 0, 0, 16'h0));
      cmd_q.push_back(make_cmd(ACT_SPARE_7, 0, 32'sh7654_3210, 0, 0, 16'h0));
      wait_all_done();

      // each phase starts only once the block has drained
      for (p = 0; p < 5; p++) begin
         write_margin(margin_plan[p]);
         queue_random_cmds(CMDS_PER_PHASE, margin_plan[p]);
         wait_all_done();
      end

      repeat (TAIL_WAIT) @(posedge clock);
      if (mismatch_count == 0 && expected_pos_q.size() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

   initial begin : watchdog
      #4_000_000;
      $display("== FAIL ==");
      $finish;
   end

endmodule

// File: point_affine_transform_unit.f
hw/rtl/pat_pkg.sv
hw/rtl/pat_cordic.sv
hw/rtl/pat_mac.sv
hw/rtl/point_affine_transform_unit.sv
test/point_affine_transform_unit_tb.sv
